// ===== rtl/quaternion_vector_rotate_core_assert.svh =====
// assertion macros used by the job queue of the quaternion rotation core
`ifndef QUATERNION_VECTOR_ROTATE_CORE_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define QVR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("qvr assertion failed");

// next-cycle implication, checked out of reset
`define QVR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("qvr assertion failed");

`endif

// ===== rtl/qvr_pkg.sv =====
// types and constants of the quaternion rotation core
package qvr_pkg;

   localparam int QW = 16;
   localparam int PW = 32;
   localparam int CW = 32;
   localparam int NW = 2 * QW + 1;
   localparam int MW = 2 * QW + 2;
   localparam int PRW = MW + PW;
   localparam int AW = PRW + 2;
   localparam int TW = AW + 1;
   localparam int DW = NW + 1;
   localparam int DIV_LAT = PW + 1;
   localparam int QUEUE_DEPTH_DEF = 4;
   localparam logic [CW-1:0] MIN_NORM_RESET = CW'(26844);

   typedef struct packed {
      logic signed [QW-1:0] quat_w;
      logic signed [QW-1:0] quat_x;
      logic signed [QW-1:0] quat_y;
      logic signed [QW-1:0] quat_z;
      logic signed [PW-1:0] point_x;
      logic signed [PW-1:0] point_y;
      logic signed [PW-1:0] point_z;
   } req_type;

   typedef struct packed {
      logic signed [PW-1:0] rotated_x;
      logic signed [PW-1:0] rotated_y;
      logic signed [PW-1:0] rotated_z;
      logic                 degenerate;
      logic                 saturated;
   } rsp_type;

   typedef struct packed {
      logic [8:0][MW-1:0] mat;
      logic [NW-1:0]      norm;
      logic               degenerate;
      logic [2:0][PW-1:0] point;
   } job_type;

endpackage

// ===== rtl/qvr_front.sv =====
// front end: quaternion products, norm test and rotation matrix
module qvr_front import qvr_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int LW = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   input  logic          csr_wr_en,
   input  logic [CW-1:0] csr_wr_data,
   input  logic [LW-1:0] queue_level,
   output logic          push,
   output job_type       job
);

   logic [CW-1:0] min_norm_ff;
   logic va_ff, vb_ff;
   logic signed [2*QW-1:0] ww_ff, xx_ff, yy_ff, zz_ff;
   logic signed [2*QW-1:0] xy_ff, wz_ff, xz_ff, wy_ff, yz_ff, wx_ff;
   logic [2:0][PW-1:0] point_a_ff;
   logic signed [2*QW-1:0] ww_in, xx_in, yy_in, zz_in;
   logic signed [2*QW-1:0] xy_in, wz_in, xz_in, wy_in, yz_in, wx_in;
   logic signed [MW-1:0] m_in [9];
   logic [NW-1:0] norm_in;
   logic [LW-1:0] occupancy;
   logic accept;
   job_type job_ff, job_in;

   // credits cover the queue plus both front stages
   assign occupancy = queue_level + LW'(va_ff) + LW'(vb_ff);
   assign req_stall = occupancy >= LW'(QUEUE_DEPTH);
   assign accept = req_valid && !req_stall;

   always_comb begin
      ww_in = req_data.quat_w * req_data.quat_w;
      xx_in = req_data.quat_x * req_data.quat_x;
      yy_in = req_data.quat_y * req_data.quat_y;
      zz_in = req_data.quat_z * req_data.quat_z;
      xy_in = req_data.quat_x * req_data.quat_y;
      wz_in = req_data.quat_w * req_data.quat_z;
      xz_in = req_data.quat_x * req_data.quat_z;
      wy_in = req_data.quat_w * req_data.quat_y;
      yz_in = req_data.quat_y * req_data.quat_z;
      wx_in = req_data.quat_w * req_data.quat_x;
   end

   always_comb begin
      norm_in = NW'(unsigned'(ww_ff)) + NW'(unsigned'(xx_ff))
              + NW'(unsigned'(yy_ff)) + NW'(unsigned'(zz_ff));
      m_in[0] = MW'(ww_ff) + MW'(xx_ff) - MW'(yy_ff) - MW'(zz_ff);
      m_in[1] = (MW'(xy_ff) - MW'(wz_ff)) <<< 1;
      m_in[2] = (MW'(xz_ff) + MW'(wy_ff)) <<< 1;
      m_in[3] = (MW'(xy_ff) + MW'(wz_ff)) <<< 1;
      m_in[4] = MW'(ww_ff) + MW'(yy_ff) - MW'(xx_ff) - MW'(zz_ff);
      m_in[5] = (MW'(yz_ff) - MW'(wx_ff)) <<< 1;
      m_in[6] = (MW'(xz_ff) - MW'(wy_ff)) <<< 1;
      m_in[7] = (MW'(yz_ff) + MW'(wx_ff)) <<< 1;
      m_in[8] = MW'(ww_ff) + MW'(zz_ff) - MW'(xx_ff) - MW'(yy_ff);
      for (int k = 0; k < 9; k++) begin
         job_in.mat[k] = m_in[k];
      end
      job_in.norm = norm_in;
      job_in.degenerate = norm_in <= NW'(min_norm_ff);
      job_in.point = point_a_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_norm_ff <= MIN_NORM_RESET;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            min_norm_ff <= csr_wr_data;
         end
         va_ff <= accept;
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      ww_ff <= ww_in;
      xx_ff <= xx_in;
      yy_ff <= yy_in;
      zz_ff <= zz_in;
      xy_ff <= xy_in;
      wz_ff <= wz_in;
      xz_ff <= xz_in;
      wy_ff <= wy_in;
      yz_ff <= yz_in;
      wx_ff <= wx_in;
      point_a_ff <= {req_data.point_z, req_data.point_y, req_data.point_x};
      job_ff <= job_in;
   end

   assign push = vb_ff;
   assign job = job_ff;

endmodule

// ===== rtl/qvr_queue.sv =====
// job queue between the front end and the back end
`include "quaternion_vector_rotate_core_assert.svh"
module qvr_queue import qvr_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
   localparam int LW = $clog2(QUEUE_DEPTH + 1),
   localparam int PTW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  job_type       push_job,
   input  logic          pop,
   output logic          not_empty,
   output job_type       head,
   output logic [LW-1:0] level
);

   job_type mem [QUEUE_DEPTH];
   logic [PTW-1:0] wr_ptr_ff, rd_ptr_ff, wr_ptr_in, rd_ptr_in;
   logic [LW-1:0] level_ff, level_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTW'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + LW'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   assign head = mem[rd_ptr_ff];
   assign not_empty = level_ff != '0;
   assign level = level_ff;

   `QVR_ASSERT_NOW(a_no_push_full, clock, reset, push, level_ff < LW'(QUEUE_DEPTH))
   `QVR_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, level_ff != '0)
   `QVR_ASSERT_NEXT(a_level_up, clock, reset, push && !pop, level_ff == $past(level_ff) + LW'(1))

endmodule

// ===== rtl/qvr_divider.sv =====
// pipelined restoring divider lane, one quotient bit per stage
module qvr_divider import qvr_pkg::*; (
   input  logic          clock,
   input  logic          en,
   input  logic [TW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [PW-1:0] quo,
   output logic          ovf
);

   logic [TW-1:0] r_ff   [PW];
   logic [DW-1:0] d_ff   [PW];
   logic [PW-1:0] q_ff   [PW+1];
   logic          ovf_ff [PW+1];

   // quotient at or above 2^PW saturates anyway
   always_ff @(posedge clock) begin
      if (en) begin
         r_ff[0] <= num;
         d_ff[0] <= den;
         q_ff[0] <= '0;
         ovf_ff[0] <= num >= (TW'(den) << PW);
      end
   end

   for (genvar i = 0; i < PW; i++) begin : g_stage
      logic [TW-1:0] trial;
      logic ge;
      assign trial = TW'(d_ff[i]) << (PW - 1 - i);
      assign ge = r_ff[i] >= trial;
      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[i+1] <= {q_ff[i][PW-2:0], ge};
            ovf_ff[i+1] <= ovf_ff[i];
         end
      end
      if (i < PW - 1) begin : g_next
         always_ff @(posedge clock) begin
            if (en) begin
               r_ff[i+1] <= ge ? r_ff[i] - trial : r_ff[i];
               d_ff[i+1] <= d_ff[i];
            end
         end
      end
   end

   assign quo = q_ff[PW];
   assign ovf = ovf_ff[PW];

endmodule

// ===== rtl/qvr_back.sv =====
// back end: matrix times point, rounded divide by the norm, saturation
module qvr_back import qvr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_not_empty,
   input  job_type q_head,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   logic adv;
   logic v1_ff, v2_ff, v3_ff;
   logic signed [PRW-1:0] prod_ff [9];
   logic signed [PRW-1:0] prod_in [9];
   logic signed [AW-1:0] acc_ff [3];
   logic [NW-1:0] norm1_ff, norm2_ff;
   logic deg1_ff, deg2_ff, deg3_ff;
   logic [2:0][PW-1:0] pt1_ff, pt2_ff, pt3_ff;
   logic [TW-1:0] t_ff [3];
   logic [TW-1:0] t_in [3];
   logic [DW-1:0] d_ff;
   logic [2:0] neg3_ff, neg3_in;
   logic [AW-1:0] mag [3];
   logic sv_ff [DIV_LAT];
   logic sdeg_ff [DIV_LAT];
   logic [2:0] sneg_ff [DIV_LAT];
   logic [2:0][PW-1:0] spt_ff [DIV_LAT];
   logic [PW-1:0] quo [3];
   logic [2:0] ovf;
   logic rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   // whole back end holds while the result register is stalled
   assign adv = !rsp_valid_ff || !rsp_stall;
   assign pop = adv && q_not_empty;

   always_comb begin
      for (int k = 0; k < 9; k++) begin
         prod_in[k] = $signed(q_head.mat[k]) * $signed(q_head.point[k % 3]);
      end
   end

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         neg3_in[c] = acc_ff[c][AW-1];
         mag[c] = neg3_in[c] ? AW'(-acc_ff[c]) : AW'(acc_ff[c]);
         // 2|a| + n over 2n rounds half away from zero
         t_in[c] = {mag[c], 1'b0} + TW'(norm2_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int s = 0; s < DIV_LAT; s++) begin
            sv_ff[s] <= 1'b0;
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= q_not_empty;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         sv_ff[0] <= v3_ff;
         for (int s = 1; s < DIV_LAT; s++) begin
            sv_ff[s] <= sv_ff[s-1];
         end
         rsp_valid_ff <= sv_ff[DIV_LAT-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < 9; k++) begin
            prod_ff[k] <= prod_in[k];
         end
         norm1_ff <= q_head.norm;
         deg1_ff <= q_head.degenerate;
         pt1_ff <= q_head.point;
         for (int c = 0; c < 3; c++) begin
            acc_ff[c] <= AW'(prod_ff[3*c]) + AW'(prod_ff[3*c+1]) + AW'(prod_ff[3*c+2]);
            t_ff[c] <= t_in[c];
         end
         norm2_ff <= norm1_ff;
         deg2_ff <= deg1_ff;
         pt2_ff <= pt1_ff;
         d_ff <= {norm2_ff, 1'b0};
         neg3_ff <= neg3_in;
         deg3_ff <= deg2_ff;
         pt3_ff <= pt2_ff;
         sdeg_ff[0] <= deg3_ff;
         sneg_ff[0] <= neg3_ff;
         spt_ff[0] <= pt3_ff;
         for (int s = 1; s < DIV_LAT; s++) begin
            sdeg_ff[s] <= sdeg_ff[s-1];
            sneg_ff[s] <= sneg_ff[s-1];
            spt_ff[s] <= spt_ff[s-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_lane
      qvr_divider u_div (
         .clock (clock),
         .en    (adv),
         .num   (t_ff[c]),
         .den   (d_ff),
         .quo   (quo[c]),
         .ovf   (ovf[c])
      );
   end

   always_comb begin
      logic [PW-1:0] val [3];
      logic [2:0] sat;
      for (int c = 0; c < 3; c++) begin
         if (sneg_ff[DIV_LAT-1][c]) begin
            sat[c] = ovf[c] || (quo[c][PW-1] && (quo[c][PW-2:0] != '0));
            val[c] = sat[c] ? {1'b1, {(PW-1){1'b0}}} : PW'(-quo[c]);
         end else begin
            sat[c] = ovf[c] || quo[c][PW-1];
            val[c] = sat[c] ? {1'b0, {(PW-1){1'b1}}} : quo[c];
         end
      end
      if (sdeg_ff[DIV_LAT-1]) begin
         rsp_in.rotated_x = spt_ff[DIV_LAT-1][0];
         rsp_in.rotated_y = spt_ff[DIV_LAT-1][1];
         rsp_in.rotated_z = spt_ff[DIV_LAT-1][2];
         rsp_in.degenerate = 1'b1;
         rsp_in.saturated = 1'b0;
      end else begin
         rsp_in.rotated_x = val[0];
         rsp_in.rotated_y = val[1];
         rsp_in.rotated_z = val[2];
         rsp_in.degenerate = 1'b0;
         rsp_in.saturated = |sat;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/quaternion_vector_rotate_core.sv =====
// Rotates a Q16.16 point by a Q2.14 quaternion, normalized by its exact squared norm.
// One item per clock in steady state while rsp is not stalled. An item passes through
// 2 front stages, the job queue, 3 matrix stages, 33 divider stages (an overflow check,
// then a quotient bit per stage, in three restoring divider lanes) and 1 output register.
// An item whose squared norm (Q4.28) is at or below csr_wr_data's register (reset
// 26844) passes its point through with degenerate set. Quotients round half away from
// zero and clamp to 32 bits with saturated set. A stall on rsp holds the whole back end;
// the front end keeps taking items until the queue of QUEUE_DEPTH jobs is spoken for.
module quaternion_vector_rotate_core import qvr_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  req_type       req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data,
   input  logic          csr_wr_en,
   input  logic [CW-1:0] csr_wr_data
);

   localparam int LW = $clog2(QUEUE_DEPTH + 1);

   logic push, pop, not_empty;
   job_type push_job, head;
   logic [LW-1:0] level;

   qvr_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .queue_level (level),
      .push        (push),
      .job         (push_job)
   );

   qvr_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .not_empty (not_empty),
      .head      (head),
      .level     (level)
   );

   qvr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_not_empty (not_empty),
      .q_head      (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule
